// ----- rtl/tpa_pkg.sv -----
package tpa_pkg;

    localparam int TOTAL_PAGES = 1024;
    localparam int PAGE_W      = $clog2(TOTAL_PAGES);
    localparam int CNT_W       = PAGE_W + 1;
    localparam int WORD_W      = 32;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int WORDS       = TOTAL_PAGES / WORD_W;
    localparam int WADDR_W     = PAGE_W - BIT_W;
    localparam int STATUS_W    = 3;

    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [CNT_W-1:0] KERNEL_RESET = CNT_W'(512);
    localparam logic [CNT_W-1:0] USER_RESET   = CNT_W'(512);

    // register index, taken from paddr above the byte lanes
    localparam logic REG_KERNEL = 1'b0;
    localparam logic REG_USER   = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_FIT    = 3'd1,
        ST_ZERO      = 3'd2,
        ST_OUTSIDE   = 3'd3,
        ST_NOT_ALLOC = 3'd4
    } status_t;

    typedef enum logic {
        WALK_POOL = 1'b0,
        WALK_RUN  = 1'b1
    } walk_sel_t;

    typedef struct packed {
        logic              operation;
        logic              pool_is_user;
        logic [PAGE_W-1:0] first_page;
        logic [CNT_W-1:0]  page_count;
    } in_item_t;

    typedef struct packed {
        logic [PAGE_W-1:0]   granted_page;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    typedef struct packed {
        logic      accept;
        logic      init_write;
        logic      walk_start;
        walk_sel_t walk_sel;
        logic      walk_stop;
        logic      scan_eval;
        logic      write_set;
        logic      write_clear;
        logic      result_load;
        status_t   result_code;
    } ctrl_cmd_t;

    typedef struct packed {
        logic init_last;
        logic op_free;
        logic dec_zero;
        logic dec_no_fit;
        logic dec_outside;
        logic dec_range_bad;
        logic eval_valid;
        logic eval_last;
        logic scan_hit;
        logic check_bad;
        logic out_busy;
    } dp_status_t;

endpackage

// ----- rtl/tpa_ctrl.sv -----
module tpa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tpa_pkg::dp_status_t stat,
    output tpa_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_INIT    = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_DECODE  = 9'b000000100,
        S_SCAN    = 9'b000001000,
        S_MARK_GO = 9'b000010000,
        S_MARK    = 9'b000100000,
        S_CHECK   = 9'b001000000,
        S_CLEAR   = 9'b010000000,
        S_DONE    = 9'b100000000
    } state_t;

    state_t           state_reg, state_next;
    tpa_pkg::status_t code_reg, code_next;

    always_comb
    begin
        state_next      = state_reg;
        code_next       = code_reg;
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.result_code = code_reg;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_write = 1'b1;
                if (stat.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.walk_stop = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.dec_zero)
                begin
                    code_next  = tpa_pkg::ST_ZERO;
                    state_next = S_DONE;
                end
                else if (stat.op_free)
                begin
                    if (stat.dec_outside)
                    begin
                        code_next  = tpa_pkg::ST_OUTSIDE;
                        state_next = S_DONE;
                    end
                    else if (stat.dec_range_bad)
                    begin
                        code_next  = tpa_pkg::ST_NOT_ALLOC;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.walk_start = 1'b1;
                        cmd.walk_sel   = tpa_pkg::WALK_RUN;
                        state_next     = S_CHECK;
                    end
                end
                else if (stat.dec_no_fit)
                begin
                    code_next  = tpa_pkg::ST_NO_FIT;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.walk_start = 1'b1;
                    cmd.walk_sel   = tpa_pkg::WALK_POOL;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_eval = 1'b1;
                if (stat.scan_hit)
                begin
                    state_next = S_MARK_GO;
                end
                else if (stat.eval_valid && stat.eval_last)
                begin
                    code_next  = tpa_pkg::ST_NO_FIT;
                    state_next = S_DONE;
                end
            end
            S_MARK_GO:
            begin
                cmd.walk_start = 1'b1;
                cmd.walk_sel   = tpa_pkg::WALK_RUN;
                state_next     = S_MARK;
            end
            S_MARK:
            begin
                cmd.write_set = 1'b1;
                if (stat.eval_valid && stat.eval_last)
                begin
                    code_next  = tpa_pkg::ST_OK;
                    state_next = S_DONE;
                end
            end
            S_CHECK:
            begin
                if (stat.check_bad)
                begin
                    code_next  = tpa_pkg::ST_NOT_ALLOC;
                    state_next = S_DONE;
                end
                else if (stat.eval_valid && stat.eval_last)
                begin
                    cmd.walk_start = 1'b1;
                    cmd.walk_sel   = tpa_pkg::WALK_RUN;
                    state_next     = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                cmd.write_clear = 1'b1;
                if (stat.eval_valid && stat.eval_last)
                begin
                    code_next  = tpa_pkg::ST_OK;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.walk_stop = 1'b1;
                if (!stat.out_busy)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            code_reg  <= tpa_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

// ----- rtl/tpa_datapath.sv -----
module tpa_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tpa_pkg::ctrl_cmd_t                  cmd,
    output tpa_pkg::dp_status_t                 stat,
    input  tpa_pkg::in_item_t                   in_data,
    input  logic [tpa_pkg::CNT_W-1:0]           kernel_cfg,
    input  logic [tpa_pkg::CNT_W-1:0]           user_cfg,
    output logic                                out_valid,
    input  logic                                out_ready,
    output tpa_pkg::out_item_t                  out_data
);

    localparam int PAGE_W  = tpa_pkg::PAGE_W;
    localparam int CNT_W   = tpa_pkg::CNT_W;
    localparam int WORD_W  = tpa_pkg::WORD_W;
    localparam int BIT_W   = tpa_pkg::BIT_W;
    localparam int WORDS   = tpa_pkg::WORDS;
    localparam int WADDR_W = tpa_pkg::WADDR_W;

    // used-bit store, one word of pages per row
    logic [WORD_W-1:0] mem [WORDS];

    tpa_pkg::in_item_t  item_reg, item_next;
    logic [CNT_W-1:0]   ks_reg, ks_next;
    logic [CNT_W-1:0]   kus_reg, kus_next;
    logic [CNT_W-1:0]   size_reg, size_next;
    logic [PAGE_W-1:0]  pool_lo_reg, pool_lo_next;
    logic [PAGE_W-1:0]  pool_hi_reg, pool_hi_next;
    logic [PAGE_W-1:0]  start_reg, start_next;
    logic [PAGE_W-1:0]  end_reg, end_next;
    logic [CNT_W-1:0]   run_reg, run_next;
    logic [WADDR_W-1:0] ptr_reg, ptr_next;
    logic [WADDR_W-1:0] last_reg, last_next;
    logic [WADDR_W-1:0] tag_reg, tag_next;
    logic               walk_active_reg, walk_active_next;
    logic               tag_valid_reg, tag_valid_next;
    logic [WORD_W-1:0]  rdata_reg;
    logic               out_valid_reg, out_valid_next;
    tpa_pkg::out_item_t out_data_reg, out_data_next;

    logic               rd_issue;
    logic               wr_en;
    logic [WORD_W-1:0]  wr_data;
    logic [WORD_W-1:0]  run_mask;
    logic [WORD_W-1:0]  pool_mask;
    logic [WORD_W-1:0]  free_bits;
    logic               lv_valid [WORD_W];
    logic [BIT_W-1:0]   lv_idx [WORD_W];
    logic [CNT_W-1:0]   run_len [WORD_W];
    logic               hit_any;
    logic [BIT_W-1:0]   hit_bit;
    logic [PAGE_W-1:0]  hit_end;
    logic [CNT_W-1:0]   hit_start_wide;
    logic [CNT_W-1:0]   acc_ks, acc_room, acc_us, acc_base, acc_size;
    logic [CNT_W-1:0]   acc_hi_wide, acc_end_wide;
    logic [CNT_W-1:0]   pool_end;
    logic [CNT_W:0]     free_end_excl;
    logic [PAGE_W-1:0]  granted;

    function automatic logic [WORD_W-1:0] range_mask(
        input logic [WADDR_W-1:0] w,
        input logic [PAGE_W-1:0]  s,
        input logic [PAGE_W-1:0]  e
    );
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        lo = (w == s[PAGE_W-1:BIT_W]) ? ({WORD_W{1'b1}} << s[BIT_W-1:0]) : {WORD_W{1'b1}};
        hi = (w == e[PAGE_W-1:BIT_W]) ? ({WORD_W{1'b1}} >> (~e[BIT_W-1:0])) : {WORD_W{1'b1}};
        return lo & hi;
    endfunction

    // effective pool sizes at accept; config must stay put while busy (the block does not enforce it)
    always_comb
    begin
        acc_ks       = (kernel_cfg > CNT_W'(tpa_pkg::TOTAL_PAGES)) ?
                       CNT_W'(tpa_pkg::TOTAL_PAGES) : kernel_cfg;
        acc_room     = CNT_W'(tpa_pkg::TOTAL_PAGES) - acc_ks;
        acc_us       = (user_cfg > acc_room) ? acc_room : user_cfg;
        acc_base     = in_data.pool_is_user ? acc_ks : '0;
        acc_size     = in_data.pool_is_user ? acc_us : acc_ks;
        acc_hi_wide  = acc_base + acc_size - CNT_W'(1);
        acc_end_wide = {1'b0, in_data.first_page} + in_data.page_count - CNT_W'(1);
    end

    // decode of the held beat, walk and output status
    always_comb
    begin
        pool_end      = ({1'b0, item_reg.first_page} < ks_reg) ? ks_reg : kus_reg;
        free_end_excl = {2'b00, item_reg.first_page} + {1'b0, item_reg.page_count};
        stat.op_free       = (item_reg.operation == tpa_pkg::OP_FREE);
        stat.dec_zero      = (item_reg.page_count == '0);
        stat.dec_no_fit    = (size_reg == '0) || (item_reg.page_count > size_reg);
        stat.dec_outside   = ({1'b0, item_reg.first_page} >= kus_reg);
        stat.dec_range_bad = (free_end_excl > {1'b0, pool_end});
        stat.eval_valid    = tag_valid_reg;
        stat.eval_last     = (tag_reg == last_reg);
        stat.scan_hit      = tag_valid_reg && hit_any;
        stat.check_bad     = tag_valid_reg && ((rdata_reg & run_mask) != run_mask);
        stat.init_last     = (ptr_reg == WADDR_W'(WORDS - 1));
        stat.out_busy      = out_valid_reg && !out_ready;
    end

    // first-fit evaluation of one word: prefix search for the nearest used bit
    always_comb
    begin
        pool_mask = range_mask(tag_reg, pool_lo_reg, pool_hi_reg);
        free_bits = ~rdata_reg & pool_mask;
        for (int j = 0; j < WORD_W; j++)
        begin
            lv_valid[j] = ~free_bits[j];
            lv_idx[j]   = BIT_W'(j);
        end
        for (int k = 0; k < BIT_W; k++)
        begin
            for (int j = WORD_W - 1; j >= 0; j--)
            begin
                if (j >= (1 << k) && !lv_valid[j])
                begin
                    lv_valid[j] = lv_valid[j - (1 << k)];
                    lv_idx[j]   = lv_idx[j - (1 << k)];
                end
            end
        end
        for (int j = 0; j < WORD_W; j++)
        begin
            run_len[j] = lv_valid[j] ? (CNT_W'(j) - CNT_W'(lv_idx[j]))
                                     : (run_reg + CNT_W'(j + 1));
        end
        hit_any = 1'b0;
        hit_bit = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (run_len[j] >= item_reg.page_count)
            begin
                hit_any = 1'b1;
                hit_bit = BIT_W'(j);
            end
        end
        hit_end        = {tag_reg, hit_bit};
        hit_start_wide = {1'b0, hit_end} + CNT_W'(1) - item_reg.page_count;
    end

    always_comb
    begin
        run_mask        = range_mask(tag_reg, start_reg, end_reg);
        rd_issue        = walk_active_reg && !cmd.walk_start && !cmd.walk_stop;
        wr_en           = tag_valid_reg && (cmd.write_set || cmd.write_clear);
        wr_data         = cmd.write_set ? (rdata_reg | run_mask) : (rdata_reg & ~run_mask);
        granted         = ((cmd.result_code == tpa_pkg::ST_OK) &&
                           (item_reg.operation == tpa_pkg::OP_ALLOC)) ? start_reg : '0;
    end

    always_comb
    begin
        item_next        = item_reg;
        ks_next          = ks_reg;
        kus_next         = kus_reg;
        size_next        = size_reg;
        pool_lo_next     = pool_lo_reg;
        pool_hi_next     = pool_hi_reg;
        start_next       = start_reg;
        end_next         = end_reg;
        run_next         = run_reg;
        ptr_next         = ptr_reg;
        last_next        = last_reg;
        tag_next         = tag_reg;
        walk_active_next = walk_active_reg;
        tag_valid_next   = 1'b0;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;

        if (cmd.accept)
        begin
            item_next    = in_data;
            ks_next      = acc_ks;
            kus_next     = acc_ks + acc_us;
            size_next    = acc_size;
            pool_lo_next = acc_base[PAGE_W-1:0];
            pool_hi_next = acc_hi_wide[PAGE_W-1:0];
            start_next   = in_data.first_page;
            end_next     = acc_end_wide[PAGE_W-1:0];
        end

        if (cmd.init_write)
        begin
            ptr_next = ptr_reg + WADDR_W'(1);
        end
        else if (cmd.walk_start)
        begin
            walk_active_next = 1'b1;
            run_next         = '0;
            if (cmd.walk_sel == tpa_pkg::WALK_POOL)
            begin
                ptr_next  = pool_lo_reg[PAGE_W-1:BIT_W];
                last_next = pool_hi_reg[PAGE_W-1:BIT_W];
            end
            else
            begin
                ptr_next  = start_reg[PAGE_W-1:BIT_W];
                last_next = end_reg[PAGE_W-1:BIT_W];
            end
        end
        else if (cmd.walk_stop)
        begin
            walk_active_next = 1'b0;
        end
        else if (walk_active_reg)
        begin
            ptr_next         = ptr_reg + WADDR_W'(1);
            walk_active_next = (ptr_reg != last_reg);
            tag_valid_next   = 1'b1;
            tag_next         = ptr_reg;
        end

        if (cmd.scan_eval && tag_valid_reg)
        begin
            run_next = run_len[WORD_W-1];
            if (hit_any)
            begin
                start_next = hit_start_wide[PAGE_W-1:0];
                end_next   = hit_end;
            end
        end

        if (cmd.result_load)
        begin
            out_valid_next             = 1'b1;
            out_data_next.granted_page = granted;
            out_data_next.status       = cmd.result_code;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg         <= '0;
            walk_active_reg <= 1'b0;
            tag_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            ptr_reg         <= ptr_next;
            walk_active_reg <= walk_active_next;
            tag_valid_reg   <= tag_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        ks_reg       <= ks_next;
        kus_reg      <= kus_next;
        size_reg     <= size_next;
        pool_lo_reg  <= pool_lo_next;
        pool_hi_reg  <= pool_hi_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        run_reg      <= run_next;
        last_reg     <= last_next;
        tag_reg      <= tag_next;
        out_data_reg <= out_data_next;
    end

    // store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.init_write)
        begin
            mem[ptr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[tag_reg] <= wr_data;
        end
        if (rd_issue)
        begin
            rdata_reg <= mem[ptr_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_issue) |-> (ptr_reg != tag_reg))
        else $error("read and write hit the same word");

    a_tag_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        tag_valid_reg |-> (tag_reg <= last_reg))
        else $error("evaluated word past end of walk");

    a_hit_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_eval && stat.scan_hit) |=>
        (start_reg >= pool_lo_reg && end_reg <= pool_hi_reg && end_reg >= start_reg))
        else $error("first-fit run outside pool");

    a_mark_free_only: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write_set && tag_valid_reg) |-> ((rdata_reg & run_mask) == '0))
        else $error("marking a page that is already used");

    a_clear_used_only: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write_clear && tag_valid_reg) |-> ((rdata_reg & run_mask) == run_mask))
        else $error("clearing a page that is not used");
`endif

endmodule

// ----- rtl/two_pool_bitmap_page_allocator_core.sv -----
// Page allocator over a used-bit store of 1024 pages: kernel pool from page 0,
// user pool right after it, sizes set through the APB registers (offset 0
// kernel_page_count, offset 4 user_page_count; write only while idle).
// Input beat: allocate (pool, count) or free (first_page, count). Each input
// beat yields exactly one output beat: granted_page plus status.
// Timing: one item at a time, in_ready is high only when the sequencer idles.
//   allocate: a scan of the store words up to the first fit, then a mark pass
//   over the words the run spans; a full kernel-pool scan is 16 words.
//   free: a check pass, then a clear pass, each over the words the run spans.
//   rejected items (zero count, no room, outside, bad range) go straight to the result.
// The cost is set by the word walk over the store: one 32-page word read per
// cycle, evaluated in the following cycle through a registered read port.
// Reset: a clearing pass writes all 32 store words to zero (in_ready low);
// APB writes are taken during it. Registers reset to 512 each.
// Stall: the result sits in an output register; a new item is accepted while
// it waits, and the sequencer holds its next result until that beat leaves.
module two_pool_bitmap_page_allocator_core (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  tpa_pkg::in_item_t            in_data,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output tpa_pkg::out_item_t           out_data,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tpa_pkg::APB_AW-1:0]   paddr,
    input  logic [tpa_pkg::APB_DW-1:0]   pwdata,
    output logic [tpa_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int CNT_W  = tpa_pkg::CNT_W;
    localparam int APB_AW = tpa_pkg::APB_AW;
    localparam int APB_DW = tpa_pkg::APB_DW;

    logic [CNT_W-1:0] kernel_cfg_reg, kernel_cfg_next;
    logic [CNT_W-1:0] user_cfg_reg, user_cfg_next;
    logic             apb_write;
    logic             reg_index;

    tpa_pkg::ctrl_cmd_t  cmd;
    tpa_pkg::dp_status_t stat;

    // register file: index sits above the byte lanes
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[APB_AW-1];

    always_comb
    begin
        kernel_cfg_next = kernel_cfg_reg;
        user_cfg_next   = user_cfg_reg;
        if (apb_write)
        begin
            if (reg_index == tpa_pkg::REG_KERNEL)
            begin
                kernel_cfg_next = pwdata[CNT_W-1:0];
            end
            else
            begin
                user_cfg_next = pwdata[CNT_W-1:0];
            end
        end
    end

    // read-back, zero-extended
    assign prdata = (reg_index == tpa_pkg::REG_USER) ?
                    {{(APB_DW-CNT_W){1'b0}}, user_cfg_reg} :
                    {{(APB_DW-CNT_W){1'b0}}, kernel_cfg_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_cfg_reg <= tpa_pkg::KERNEL_RESET;
            user_cfg_reg   <= tpa_pkg::USER_RESET;
        end
        else
        begin
            kernel_cfg_reg <= kernel_cfg_next;
            user_cfg_reg   <= user_cfg_next;
        end
    end

    // sequencer: init sweep, decode, scan/mark or check/clear, result handoff
    tpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store, word walker, first-fit search and output register
    tpa_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_data    (in_data),
        .kernel_cfg (kernel_cfg_reg),
        .user_cfg   (user_cfg_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

// ----- bench/tpa_grant_checker.sv -----
module tpa_grant_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  tpa_pkg::in_item_t          in_data,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  tpa_pkg::out_item_t         out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tpa_pkg::APB_AW-1:0] paddr,
    input  logic [tpa_pkg::APB_DW-1:0] pwdata,
    input  logic                       pready,
    output int                         fail_count,
    output int                         pending_beats
);
    import tpa_pkg::*;

    // shadow of the used-bit store and the two pool size registers
    bit               page_taken [TOTAL_PAGES];
    logic [CNT_W-1:0] kernel_reg;
    logic [CNT_W-1:0] user_reg;
    out_item_t        expected_grants [$];
    out_item_t        want;

    function automatic out_item_t predict_allocation(in_item_t req);
        out_item_t res;
        int        ks;
        int        us;
        int        base;
        int        span;
        int        run_len;
        int        stop;
        bit        whole;
        res = '0;
        ks  = (kernel_reg > TOTAL_PAGES) ? TOTAL_PAGES : int'(kernel_reg);
        us  = (user_reg > TOTAL_PAGES - ks) ? TOTAL_PAGES - ks : int'(user_reg);
        if (req.page_count == 0) begin
            res.status = ST_ZERO;
        end else if (req.operation == OP_ALLOC) begin
            base       = req.pool_is_user ? ks : 0;
            span       = req.pool_is_user ? us : ks;
            run_len    = 0;
            res.status = ST_NO_FIT;
            // first fit: lowest window of page_count free pages
            for (int i = 0; i < span; i++) begin
                if (page_taken[base + i]) begin
                    run_len = 0;
                end else begin
                    run_len++;
                    if (run_len == int'(req.page_count)) begin
                        for (int j = base + i + 1 - run_len; j <= base + i; j++)
                            page_taken[j] = 1'b1;
                        res.granted_page = PAGE_W'(base + i + 1 - run_len);
                        res.status       = ST_OK;
                        break;
                    end
                end
            end
        end else begin
            if (int'(req.first_page) < ks)
                stop = ks;
            else if (int'(req.first_page) < ks + us)
                stop = ks + us;
            else
                stop = -1;
            if (stop < 0) begin
                res.status = ST_OUTSIDE;
            end else if (int'(req.first_page) + int'(req.page_count) > stop) begin
                res.status = ST_NOT_ALLOC;
            end else begin
                whole = 1'b1;
                for (int j = 0; j < int'(req.page_count); j++)
                    if (!page_taken[int'(req.first_page) + j])
                        whole = 1'b0;
                if (whole) begin
                    for (int j = 0; j < int'(req.page_count); j++)
                        page_taken[int'(req.first_page) + j] = 1'b0;
                    res.status = ST_OK;
                end else begin
                    res.status = ST_NOT_ALLOC;
                end
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            foreach (page_taken[p])
                page_taken[p] = 1'b0;
            kernel_reg    = KERNEL_RESET;
            user_reg      = USER_RESET;
            expected_grants.delete();
            fail_count    = 0;
            pending_beats = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[APB_AW-1:2] == REG_KERNEL)
                    kernel_reg = pwdata[CNT_W-1:0];
                else if (paddr[APB_AW-1:2] == REG_USER)
                    user_reg = pwdata[CNT_W-1:0];
            end
            if (in_valid && in_ready)
                expected_grants.push_back(predict_allocation(in_data));
            if (out_valid && out_ready) begin
                if (expected_grants.size() == 0) begin
                    $error("result beat with nothing expected: granted_page %0d status %0d",
                           out_data.granted_page, out_data.status);
                    fail_count++;
                end else begin
                    want = expected_grants.pop_front();
                    if (out_data.granted_page !== want.granted_page) begin
                        $error("granted_page expected %0d got %0d",
                               want.granted_page, out_data.granted_page);
                        fail_count++;
                    end
                    if (out_data.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, out_data.status);
                        fail_count++;
                    end
                end
            end
            pending_beats = expected_grants.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// Bench for the two-pool page allocator.
// The top drives requests, the result-side ready and the APB port; the checker
// beside the DUT mirrors the store and registers and scores every result beat.
// The top keeps its own list of live runs (from granted allocations) only so it
// can issue frees that hit real allocations: without that, nearly every free
// would bounce with "run not allocated" and the clear path would go untested.
module tb;
    import tpa_pkg::*;

    localparam int ITEMS_PER_PHASE = 160;
    localparam int PHASES          = 8;
    localparam int DRAIN_CYCLES    = 100;   // longer than the worst item takes
    localparam int TIMEOUT_CYCLES  = 2_000_000;

    // one request on its way through the DUT; tracked ones feed the run list
    typedef struct {
        in_item_t item;
        bit       tracked;
    } sent_req_t;

    typedef struct {
        int unsigned first;
        int unsigned count;
    } run_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    in_item_t           in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    out_item_t          out_data;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [APB_AW-1:0]  paddr     = '0;
    logic [APB_DW-1:0]  pwdata    = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    int                 fail_count;
    int                 pending_beats;

    // idle knobs, percent of cycles
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;

    sent_req_t          sent_reqs [$];
    run_t               live_runs [$];
    sent_req_t          done_req;
    run_t               back_run;

    two_pool_bitmap_page_allocator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    tpa_grant_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending_beats (pending_beats)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #(TIMEOUT_CYCLES * 10);
        $display("FAIL");
        $finish;
    end

    // Result side: ready toggles at random per the current stall knob.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Run bookkeeping for stimulus. Results come back in request order, so the
    // oldest sent request owns each result beat. A granted allocation becomes a
    // live run; a tracked free that bounced (pool bounds moved, or noise freed
    // part of it) goes back on the list so it can be retried later.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready && sent_reqs.size() > 0) begin
            done_req = sent_reqs.pop_front();
            if (done_req.tracked) begin
                if (done_req.item.operation == OP_ALLOC && out_data.status == ST_OK) begin
                    back_run.first = out_data.granted_page;
                    back_run.count = done_req.item.page_count;
                    live_runs.push_back(back_run);
                end else if (done_req.item.operation == OP_FREE
                             && out_data.status != ST_OK) begin
                    back_run.first = done_req.item.first_page;
                    back_run.count = done_req.item.page_count;
                    live_runs.push_back(back_run);
                end
            end
        end
    end

    // One request beat. Valid goes up at a falling edge (after an optional
    // random gap) and holds until the rising edge where ready is seen high.
    // Valid is left high on return so back-to-back beats need no drop.
    task automatic send_item(input in_item_t it, input bit tracked);
        sent_req_t rec;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        rec.item    = it;
        rec.tracked = tracked;
        sent_reqs.push_back(rec);
    endtask

    // Stop sending and wait for every outstanding result beat.
    task automatic wait_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_beats != 0)
            @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle; upper data bits get junk that
    // the 11-bit register must drop.
    task automatic apb_write(input logic idx, input logic [CNT_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & ~32'h7FF) | APB_DW'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_pools(input int kpages, input int upages);
        apb_write(REG_KERNEL, CNT_W'(kpages));
        apb_write(REG_USER, CNT_W'(upages));
    endtask

    // Mostly short runs so scans stay short; a few big ones and a few
    // counts past the store size (bit 10 set).
    function automatic logic [CNT_W-1:0] rand_count();
        int p;
        p = $urandom_range(99);
        if (p < 85)
            return CNT_W'($urandom_range(16, 1));
        else if (p < 95)
            return CNT_W'($urandom_range(128, 17));
        else if (p < 99)
            return CNT_W'($urandom_range(1024, 129));
        else
            return CNT_W'($urandom_range(2047, 0));
    endfunction

    task automatic send_op(input logic op, input logic user, input int page, input int cnt);
        in_item_t it;
        it.operation    = op;
        it.pool_is_user = user;
        it.first_page   = PAGE_W'(page);
        it.page_count   = CNT_W'(cnt);
        send_item(it, 1'b1);
    endtask

    // Free a live run: whole most of the time, otherwise a leading slice,
    // which leaves the tail allocated.
    task automatic free_live_run();
        in_item_t it;
        int       idx;
        int       n;
        idx = $urandom_range(live_runs.size() - 1);
        it.operation    = OP_FREE;
        it.pool_is_user = 1'($urandom);
        it.first_page   = PAGE_W'(live_runs[idx].first);
        if ($urandom_range(9) < 3 && live_runs[idx].count > 1) begin
            n = $urandom_range(live_runs[idx].count - 1, 1);
            live_runs[idx].first += n;
            live_runs[idx].count -= n;
        end else begin
            n = live_runs[idx].count;
            live_runs.delete(idx);
        end
        it.page_count = CNT_W'(n);
        send_item(it, 1'b1);
    endtask

    task automatic random_item();
        in_item_t it;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            // allocate; first_page is don't-care here, so it gets junk
            it.operation    = OP_ALLOC;
            it.pool_is_user = 1'($urandom);
            it.first_page   = PAGE_W'($urandom);
            it.page_count   = rand_count();
            send_item(it, 1'b1);
        end else if (pick < 88 && live_runs.size() > 0) begin
            free_live_run();
        end else begin
            // noise: any op, any page, sometimes a zero count
            it.operation    = 1'($urandom);
            it.pool_is_user = 1'($urandom);
            it.first_page   = PAGE_W'($urandom);
            it.page_count   = ($urandom_range(3) == 0) ? '0 : rand_count();
            send_item(it, it.operation == OP_ALLOC);
        end
    endtask

    // Idle pattern per phase: none, sender gaps, receiver stalls, light both.
    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
        endcase
    endtask

    // Pool settings per phase; phase 0 runs on reset values. Covers empty
    // pools, a full-store kernel, counts past the store (clamped), odd sizes.
    task automatic apply_setting(input int phase);
        case (phase)
            1: set_pools(100, 37);
            2: set_pools(0, 1024);
            3: set_pools(1024, 0);
            4: set_pools(2047, 2047);
            5: set_pools(1, 1);
            6: set_pools(300, 900);
            7: set_pools(700, 2047);
            default: ;
        endcase
    endtask

    initial
    begin
        int n_live;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed, reset pools (512 kernel, 512 user) ----
        send_op(OP_ALLOC, 1'b0, 0, 0);          // zero count on allocate
        send_op(OP_FREE,  1'b0, 1023, 0);       // zero count on free, no pool check
        send_op(OP_ALLOC, 1'b0, 0, 1);          // page 0
        send_op(OP_ALLOC, 1'b1, 0, 1);          // first user page, 512
        send_op(OP_ALLOC, 1'b0, 0, 513);        // bigger than the kernel pool
        send_op(OP_ALLOC, 1'b1, 1023, 1024);    // bigger than the user pool
        send_op(OP_ALLOC, 1'b0, 0, 2047);       // largest count
        send_op(OP_ALLOC, 1'b0, 0, 511);        // fills the kernel pool
        send_op(OP_ALLOC, 1'b0, 0, 1);          // kernel full
        send_op(OP_FREE,  1'b0, 0, 512);        // whole kernel pool back
        send_op(OP_FREE,  1'b1, 0, 1);          // double free
        send_op(OP_FREE,  1'b0, 511, 2);        // run crosses the kernel pool end
        send_op(OP_ALLOC, 1'b1, 0, 511);        // fills the user pool from 513
        send_op(OP_FREE,  1'b0, 1023, 1);       // last page of the store
        send_op(OP_ALLOC, 1'b1, 0, 1);          // refills page 1023
        send_op(OP_FREE,  1'b0, 512, 512);      // whole user pool back
        send_op(OP_FREE,  1'b0, 1023, 1);       // already free
        send_op(OP_ALLOC, 1'b0, 0, 3);          // 0..2
        send_op(OP_ALLOC, 1'b0, 0, 2);          // 3..4
        send_op(OP_FREE,  1'b1, 0, 3);          // hole at 0..2
        send_op(OP_ALLOC, 1'b0, 1023, 2);       // lands in the hole at 0
        send_op(OP_ALLOC, 1'b0, 0, 2);          // page 2 alone is too short: 5
        send_op(OP_FREE,  1'b0, 1, 1);          // last page of a run
        wait_results();

        // both pools empty: every nonzero allocate fails, every free is outside
        set_pools(0, 0);
        send_op(OP_ALLOC, 1'b0, 0, 1);
        send_op(OP_ALLOC, 1'b1, 0, 1);
        send_op(OP_FREE,  1'b0, 0, 1);
        wait_results();
        set_pools(512, 512);

        // ---- random phases ----
        // The live runs are updated from result beats, so they are only
        // complete once nothing is pending; every phase boundary drains first,
        // which is also when the pool registers may move.
        for (int phase = 0; phase < PHASES; phase++) begin
            apply_setting(phase);
            set_idling(phase);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                random_item();
                // now and then hold the sender until every result is back
                if ($urandom_range(99) == 0)
                    wait_results();
            end
            wait_results();
            // every other phase, hand back what is live; the rest carry
            // allocations across the register change
            if (phase % 2 == 1) begin
                n_live = live_runs.size();
                for (int k = 0; k < n_live; k++) begin
                    back_run = live_runs.pop_front();
                    send_op(OP_FREE, 1'($urandom), back_run.first, back_run.count);
                end
                wait_results();
            end
        end

        wait_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_beats == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
